// File: design/cubic_bezier_point_eval_defines.svh
// assertion macros shared by the bezier evaluator rtl
// no dependencies; included by the modules that carry assertions
`ifndef CUBIC_BEZIER_POINT_EVAL_DEFINES_SVH
`define CUBIC_BEZIER_POINT_EVAL_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define BCZ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BCZ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bcz_pkg.sv
// shared types and constants of the cubic bezier point evaluator
// no dependencies
`default_nettype none

package bcz_pkg;

    localparam int COORD_W  = 9;
    localparam int STEP_W   = 7;
    localparam int NUM_CTRL = 4;
    localparam int REG_IDX_W = 3;

    typedef logic [COORD_W-1:0] t_coord;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CTRL0_X = 3'd0,
        REG_CTRL0_Y = 3'd1,
        REG_CTRL1_X = 3'd2,
        REG_CTRL1_Y = 3'd3,
        REG_CTRL2_X = 3'd4,
        REG_CTRL2_Y = 3'd5,
        REG_CTRL3_X = 3'd6,
        REG_CTRL3_Y = 3'd7
    } t_reg_idx;

endpackage

`default_nettype wire

// File: design/bcz_weight.sv
// three-stage pipeline: clamps the step and forms the four bernstein weights
// depends on bcz_pkg and the assertion macro header
`default_nettype none
`include "cubic_bezier_point_eval_defines.svh"

module bcz_weight #(
    parameter int STEPS = 100
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  wire logic [bcz_pkg::STEP_W-1:0]     i_step,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output      logic [3:0][3*$clog2(STEPS+1)-1:0] o_w
);
    import bcz_pkg::*;

    localparam int SW  = $clog2(STEPS + 1);
    localparam int WW  = 3 * SW;
    localparam int NST = 3;
    localparam longint unsigned DEN = longint'(STEPS) * STEPS * STEPS;

    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    // stage a: clamped step and its complement
    logic [SW-1:0]   r_a_i, r_a_r, n_a_i;
    // stage b: second-order products
    logic [SW-1:0]   r_b_i, r_b_r;
    logic [2*SW-1:0] r_b_i2, r_b_r2, r_b_ir;
    // stage c: weights
    logic [WW-1:0]   r_w0, r_w1, r_w2, r_w3;
    logic [WW-1:0]   n_t1, n_t2;

    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_out_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_in_valid;
            for (int k = 1; k < NST; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_comb begin
        if (32'(i_step) > STEPS) begin
            n_a_i = SW'(STEPS);
        end else begin
            n_a_i = SW'(i_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a_i <= n_a_i;
            r_a_r <= SW'(STEPS) - n_a_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_b_i  <= r_a_i;
            r_b_r  <= r_a_r;
            r_b_i2 <= (2*SW)'(r_a_i) * (2*SW)'(r_a_i);
            r_b_r2 <= (2*SW)'(r_a_r) * (2*SW)'(r_a_r);
            r_b_ir <= (2*SW)'(r_a_i) * (2*SW)'(r_a_r);
        end
    end

    // the weights are binomial terms of s^3, so they fit ww bits after the times-three
    assign n_t1 = WW'(r_b_ir) * WW'(r_b_r);
    assign n_t2 = WW'(r_b_ir) * WW'(r_b_i);

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_w0 <= WW'(r_b_r2) * WW'(r_b_r);
            r_w1 <= (n_t1 << 1) + n_t1;
            r_w2 <= (n_t2 << 1) + n_t2;
            r_w3 <= WW'(r_b_i2) * WW'(r_b_i);
        end
    end

    assign o_w = {r_w3, r_w2, r_w1, r_w0};

    `BCZ_ASSERT_IMP(a_weight_sum, i_clk, i_rst_n, r_v[2],
        ((WW+2)'(r_w0) + (WW+2)'(r_w1) + (WW+2)'(r_w2) + (WW+2)'(r_w3))
            == (WW+2)'(DEN),
        "bernstein weights do not sum to steps cubed")
    `BCZ_ASSERT_IMP(a_step_split, i_clk, i_rst_n, r_v[0],
        (32'(r_a_i) + 32'(r_a_r)) == STEPS,
        "step and complement do not add up to steps")
    `BCZ_ASSERT_NXT(a_step_clamp, i_clk, i_rst_n,
        i_in_valid && en[0] && (32'(i_step) > STEPS),
        32'(r_a_i) == STEPS,
        "step beyond the end was not clamped")

endmodule

`default_nettype wire

// File: design/bcz_mac.sv
// two-stage pipeline: weights times control coordinates, then the per-axis sums
// depends on bcz_pkg
`default_nettype none

module bcz_mac #(
    parameter int STEPS = 100
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output      logic                                  o_in_ready,
    input  wire logic [3:0][3*$clog2(STEPS+1)-1:0]     i_w,
    input  wire bcz_pkg::t_coord                       i_ctrl_x [bcz_pkg::NUM_CTRL],
    input  wire bcz_pkg::t_coord                       i_ctrl_y [bcz_pkg::NUM_CTRL],
    output      logic                                  o_out_valid,
    input  wire logic                                  i_out_ready,
    output      logic [3*$clog2(STEPS+1)+bcz_pkg::COORD_W-1:0] o_num_x,
    output      logic [3*$clog2(STEPS+1)+bcz_pkg::COORD_W-1:0] o_num_y
);
    import bcz_pkg::*;

    localparam int SW  = $clog2(STEPS + 1);
    localparam int NW  = 3 * SW + COORD_W;
    localparam int NST = 2;

    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    logic [NW-1:0] r_px [NUM_CTRL];
    logic [NW-1:0] r_py [NUM_CTRL];
    logic [NW-1:0] r_sx, r_sy;

    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_out_ready;
        en[0]     = !r_v[0] || en[1];
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_in_valid;
            if (en[1]) r_v[1] <= r_v[0];
        end
    end

    // the user must change control points only while the pipeline is empty; the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int k = 0; k < NUM_CTRL; k++) begin
                r_px[k] <= NW'(i_w[k]) * NW'(i_ctrl_x[k]);
                r_py[k] <= NW'(i_w[k]) * NW'(i_ctrl_y[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_sx <= r_px[0] + r_px[1] + r_px[2] + r_px[3];
            r_sy <= r_py[0] + r_py[1] + r_py[2] + r_py[3];
        end
    end

    assign o_num_x = r_sx;
    assign o_num_y = r_sy;

endmodule

`default_nettype wire

// File: design/bcz_div.sv
// two-stage divider by the constant steps cubed, done as a multiply by a scaled reciprocal
// depends on bcz_pkg and the assertion macro header
`default_nettype none
`include "cubic_bezier_point_eval_defines.svh"

module bcz_div #(
    parameter int STEPS = 100
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output      logic                                  o_in_ready,
    input  wire logic [3*$clog2(STEPS+1)+bcz_pkg::COORD_W-1:0] i_num_x,
    input  wire logic [3*$clog2(STEPS+1)+bcz_pkg::COORD_W-1:0] i_num_y,
    output      logic                                  o_out_valid,
    input  wire logic                                  i_out_ready,
    output      bcz_pkg::t_coord                       o_quot_x,
    output      bcz_pkg::t_coord                       o_quot_y
);
    import bcz_pkg::*;

    localparam int SW  = $clog2(STEPS + 1);
    localparam int NW  = 3 * SW + COORD_W;
    localparam int NST = 2;
    localparam longint unsigned DEN = longint'(STEPS) * STEPS * STEPS;
    // numerator is at most 511 times the divisor, so a shift of 9 + 2*log2(den)
    // keeps the reciprocal error below one quotient step
    localparam int DW  = $clog2(DEN);
    localparam int SH  = COORD_W + 2 * DW;
    localparam int MW  = COORD_W + DW + 1;
    localparam int LW  = MW / 2;
    localparam int HW  = MW - LW;
    localparam int PW  = NW + MW;
    localparam int QFW = PW - SH;
    localparam logic [127:0] RECIP_WIDE =
        ((128'd1 << SH) + 128'(DEN) - 128'd1) / 128'(DEN);
    localparam logic [MW-1:0] RECIP    = MW'(RECIP_WIDE);
    localparam logic [LW-1:0] RECIP_LO = RECIP[LW-1:0];
    localparam logic [HW-1:0] RECIP_HI = RECIP[MW-1:LW];

    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    logic [NW+LW-1:0] r_plo_x, r_plo_y;
    logic [NW+HW-1:0] r_phi_x, r_phi_y;
    logic [PW-1:0]    n_prod_x, n_prod_y;
    logic [QFW-1:0]   r_qw_x, r_qw_y;

    always_comb begin
        en[NST-1] = !r_v[NST-1] || i_out_ready;
        en[0]     = !r_v[0] || en[1];
    end

    assign o_in_ready  = en[0];
    assign o_out_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_in_valid;
            if (en[1]) r_v[1] <= r_v[0];
        end
    end

    // reciprocal split in halves to keep each multiplier narrow
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_plo_x <= (NW+LW)'(i_num_x) * (NW+LW)'(RECIP_LO);
            r_phi_x <= (NW+HW)'(i_num_x) * (NW+HW)'(RECIP_HI);
            r_plo_y <= (NW+LW)'(i_num_y) * (NW+LW)'(RECIP_LO);
            r_phi_y <= (NW+HW)'(i_num_y) * (NW+HW)'(RECIP_HI);
        end
    end

    assign n_prod_x = (PW'(r_phi_x) << LW) + PW'(r_plo_x);
    assign n_prod_y = (PW'(r_phi_y) << LW) + PW'(r_plo_y);

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_qw_x <= n_prod_x[PW-1:SH];
            r_qw_y <= n_prod_y[PW-1:SH];
        end
    end

    assign o_quot_x = r_qw_x[COORD_W-1:0];
    assign o_quot_y = r_qw_y[COORD_W-1:0];

    `BCZ_ASSERT_IMP(a_quot_range, i_clk, i_rst_n, r_v[NST-1],
        (r_qw_x[QFW-1:COORD_W] == '0) && (r_qw_y[QFW-1:COORD_W] == '0),
        "quotient exceeds the coordinate range")
    `BCZ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_quot_x) && $stable(o_quot_y),
        "stalled result changed or dropped")
    `BCZ_ASSERT_IMP(a_ready_chain, i_clk, i_rst_n, i_out_ready,
        o_in_ready,
        "divider stalls although the output side is ready")

endmodule

`default_nettype wire

// File: design/cubic_bezier_point_eval.sv
// top level of the cubic bezier point evaluator: config registers and pipeline wiring
// depends on bcz_pkg, bcz_weight, bcz_mac, bcz_div and the assertion macro header
//
// usage:
//   the four control points are written over the config port (i_cfg_we, i_cfg_idx,
//   i_cfg_wdata) while no transaction is in flight; index 0..7 selects
//   ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, ctrl3_x, ctrl3_y.
//   each slave transaction carries one step index i; a step above STEPS is taken
//   as STEPS. each step yields exactly one master transaction with the curve point
//   floor(sum of bernstein weight times control coordinate / STEPS^3) for x and y.
//   seven register stages: 3 form the weights, 2 multiply and sum, 2 multiply by a
//   scaled reciprocal of STEPS^3 and pick the quotient bits. throughput is one
//   transaction per cycle while m_axis_tready stays high. each stage holds its data
//   while the next one is full and stalled, so a stall of the receiver fills the
//   bubbles first; s_axis_tready drops only once every stage holds an item. nothing
//   is lost or repeated across a stall.
//   reset (synchronous, active low) empties the pipeline and clears all control
//   points to zero.
`default_nettype none
`include "cubic_bezier_point_eval_defines.svh"

module cubic_bezier_point_eval #(
    parameter int STEPS = 100
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config write port
    input  wire logic                          i_cfg_we,
    input  wire logic [bcz_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bcz_pkg::COORD_W-1:0]   i_cfg_wdata,
    // step channel
    input  wire logic                          s_axis_tvalid,
    output      logic                          s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,   // [6:0] step_index
    // point channel
    output      logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output      logic [23:0]                   m_axis_tdata    // [8:0] point_x, [17:9] point_y
);
    import bcz_pkg::*;

    localparam int SW = $clog2(STEPS + 1);
    localparam int WW = 3 * SW;
    localparam int NW = 3 * SW + COORD_W;

    t_coord r_ctrl_x [NUM_CTRL];
    t_coord r_ctrl_y [NUM_CTRL];

    logic               w_valid, w_ready;
    logic [3:0][WW-1:0] w_weights;
    logic               m_valid, m_ready;
    logic [NW-1:0]      m_num_x, m_num_y;
    t_coord             q_x, q_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CTRL; k++) begin
                r_ctrl_x[k] <= '0;
                r_ctrl_y[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_CTRL0_X: r_ctrl_x[0] <= i_cfg_wdata;
                REG_CTRL0_Y: r_ctrl_y[0] <= i_cfg_wdata;
                REG_CTRL1_X: r_ctrl_x[1] <= i_cfg_wdata;
                REG_CTRL1_Y: r_ctrl_y[1] <= i_cfg_wdata;
                REG_CTRL2_X: r_ctrl_x[2] <= i_cfg_wdata;
                REG_CTRL2_Y: r_ctrl_y[2] <= i_cfg_wdata;
                REG_CTRL3_X: r_ctrl_x[3] <= i_cfg_wdata;
                REG_CTRL3_Y: r_ctrl_y[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    bcz_weight #(
        .STEPS (STEPS)
    ) u_weight (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_step      (s_axis_tdata[STEP_W-1:0]),
        .o_out_valid (w_valid),
        .i_out_ready (w_ready),
        .o_w         (w_weights)
    );

    bcz_mac #(
        .STEPS (STEPS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_valid),
        .o_in_ready  (w_ready),
        .i_w         (w_weights),
        .i_ctrl_x    (r_ctrl_x),
        .i_ctrl_y    (r_ctrl_y),
        .o_out_valid (m_valid),
        .i_out_ready (m_ready),
        .o_num_x     (m_num_x),
        .o_num_y     (m_num_y)
    );

    bcz_div #(
        .STEPS (STEPS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (m_valid),
        .o_in_ready  (m_ready),
        .i_num_x     (m_num_x),
        .i_num_y     (m_num_y),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_quot_x    (q_x),
        .o_quot_y    (q_y)
    );

    // quotient never exceeds the largest control coordinate, so nine bits need no clamp
    assign m_axis_tdata = {6'd0, q_y, q_x};

    `BCZ_ASSERT_IMP(a_top_ready, i_clk, i_rst_n, m_axis_tready,
        s_axis_tready,
        "input side stalled although the output side is ready")
    `BCZ_ASSERT_IMP(a_top_empty, i_clk, i_rst_n, !m_axis_tvalid,
        s_axis_tready,
        "input side stalled with no result waiting")
    `BCZ_ASSERT_NXT(a_top_reset, i_clk, 1'b1, !i_rst_n,
        !m_axis_tvalid && s_axis_tready,
        "pipeline not empty after reset")

endmodule

`default_nettype wire
